// ===== src/expression_tokenizer_assert.svh =====
// assertion macros used by the tokenizer top level
`ifndef EXPRESSION_TOKENIZER_ASSERT_SVH
`define EXPRESSION_TOKENIZER_ASSERT_SVH

// condition holds at every edge outside reset
`define ET_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ET_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/et_pkg.sv =====
// types and constants of the expression tokenizer
`default_nettype none

package et_pkg;

  typedef enum logic [4:0] {
    TK_ADD      = 5'd0,
    TK_SUB      = 5'd1,
    TK_MUL      = 5'd2,
    TK_DIV      = 5'd3,
    TK_AND      = 5'd4,
    TK_OR       = 5'd5,
    TK_XOR      = 5'd6,
    TK_EQUAL    = 5'd7,
    TK_EOL      = 5'd8,
    TK_CHAR     = 5'd9,
    TK_LPAREN   = 5'd10,
    TK_RPAREN   = 5'd11,
    TK_NUM      = 5'd12,
    TK_WORDCHAR = 5'd13,
    TK_WORDEND  = 5'd14,
    TK_EOF      = 5'd15,
    TK_ERROR    = 5'd16
  } token_kind_t;

  typedef enum logic [2:0] {
    LM_IDLE      = 3'd0,
    LM_NUMBER    = 3'd1,
    LM_WORD      = 3'd2,
    LM_LIT_OPEN  = 3'd3,
    LM_LIT_ESC   = 3'd4,
    LM_LIT_CLOSE = 3'd5
  } lex_mode_t;

  localparam int VALUE_W = 31;
  localparam logic [VALUE_W-1:0] NUM_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    token_kind_t        kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } token_t;

  // what the lexer hands to the token queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } lex_push_t;

  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_BAR    = 8'h7C;

endpackage

`default_nettype wire

// ===== src/et_char_if.sv =====
// input channel: one byte or an end-of-text mark per item
`default_nettype none

interface et_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== src/et_token_if.sv =====
// output channel: one token per item
`default_nettype none

interface et_token_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [30:0] token_value;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_value, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input token_value, input last_of_run,
                output ready);
endinterface

`default_nettype wire

// ===== src/et_lexer.sv =====
// input register, lexer state and per-byte token decode
`default_nettype none

module et_lexer
  import et_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output lex_push_t  push
);

  logic               stage_valid;
  logic [7:0]         stage_char;
  logic               stage_eot;
  lex_mode_t          mode;
  lex_mode_t          mode_next;
  logic [VALUE_W-1:0] acc;
  logic [VALUE_W-1:0] acc_next;

  // decode of the byte as if the lexer were idle
  logic               id_emit;
  token_kind_t        id_kind;
  logic [VALUE_W-1:0] id_value;
  lex_mode_t          id_mode;
  logic [VALUE_W-1:0] id_acc;

  logic               is_digit;
  logic               is_delim;
  logic [VALUE_W+3:0] mul_sum;
  logic [VALUE_W-1:0] acc_sat;

  logic               pre_valid;
  token_t             pre_tok;
  logic               post_valid;
  token_t             post_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= load;
    end
    if (load) begin
      stage_char <= char_code;
      stage_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= LM_IDLE;
      acc  <= '0;
    end else if (stage_valid) begin
      mode <= mode_next;
      acc  <= acc_next;
    end
  end

  assign is_digit = (stage_char >= CH_ZERO) && (stage_char <= CH_NINE);
  assign is_delim = (stage_char == CH_SPACE) || (stage_char == CH_TAB) ||
                    (stage_char == CH_LPAREN);

  // acc * 10 + digit, saturating
  assign mul_sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} +
                   {(VALUE_W + 0)'(0), stage_char[3:0]};
  assign acc_sat = (mul_sum > {4'b0000, NUM_MAX}) ? NUM_MAX : mul_sum[VALUE_W-1:0];

  always_comb begin
    id_emit  = 1'b1;
    id_kind  = TK_WORDCHAR;
    id_value = '0;
    id_mode  = LM_IDLE;
    id_acc   = '0;
    unique case (stage_char)
      CH_PLUS:   id_kind = TK_ADD;
      CH_MINUS:  id_kind = TK_SUB;
      CH_STAR:   id_kind = TK_MUL;
      CH_SLASH:  id_kind = TK_DIV;
      CH_AMP:    id_kind = TK_AND;
      CH_BAR:    id_kind = TK_OR;
      CH_CARET:  id_kind = TK_XOR;
      CH_EQUALS: id_kind = TK_EQUAL;
      CH_DOLLAR: id_kind = TK_EQUAL;
      CH_LF:     id_kind = TK_EOL;
      CH_LPAREN: id_kind = TK_LPAREN;
      CH_RPAREN: id_kind = TK_RPAREN;
      CH_SPACE:  id_emit = 1'b0;
      CH_TAB:    id_emit = 1'b0;
      CH_QUOTE: begin
        id_emit = 1'b0;
        id_mode = LM_LIT_OPEN;
      end
      default: begin
        if (is_digit) begin
          id_emit = 1'b0;
          id_mode = LM_NUMBER;
          id_acc  = {(VALUE_W - 4)'(0), stage_char[3:0]};
        end else begin
          id_mode  = LM_WORD;
          id_value = {(VALUE_W - 8)'(0), stage_char};
        end
      end
    endcase
  end

  always_comb begin
    pre_valid  = 1'b0;
    pre_tok    = '{kind: TK_ERROR, value: '0, last: 1'b0};
    post_valid = 1'b0;
    post_tok   = '{kind: TK_EOF, value: '0, last: 1'b0};
    mode_next  = mode;
    acc_next   = acc;
    if (stage_eot) begin
      post_valid = 1'b1;
      mode_next  = LM_IDLE;
      acc_next   = '0;
      unique case (mode)
        LM_NUMBER: begin
          pre_valid    = 1'b1;
          pre_tok.kind = TK_NUM;
          pre_tok.value = acc;
        end
        LM_WORD: begin
          pre_valid    = 1'b1;
          pre_tok.kind = TK_WORDEND;
        end
        LM_LIT_OPEN, LM_LIT_ESC, LM_LIT_CLOSE: begin
          pre_valid = 1'b1;
        end
        default: ;
      endcase
    end else begin
      unique case (mode)
        LM_NUMBER: begin
          if (is_digit) begin
            acc_next = acc_sat;
          end else begin
            pre_valid     = 1'b1;
            pre_tok.kind  = TK_NUM;
            pre_tok.value = acc;
            post_valid    = id_emit;
            post_tok.kind = id_kind;
            post_tok.value = id_value;
            mode_next     = id_mode;
            acc_next      = id_acc;
          end
        end
        LM_WORD: begin
          if (is_delim) begin
            pre_valid     = 1'b1;
            pre_tok.kind  = TK_WORDEND;
            post_valid    = id_emit;
            post_tok.kind = id_kind;
            post_tok.value = id_value;
            mode_next     = id_mode;
            acc_next      = id_acc;
          end else begin
            post_valid     = 1'b1;
            post_tok.kind  = TK_WORDCHAR;
            post_tok.value = {(VALUE_W - 8)'(0), stage_char};
          end
        end
        LM_LIT_OPEN: begin
          if (stage_char == CH_BSLASH) begin
            mode_next = LM_LIT_ESC;
          end else begin
            mode_next = LM_LIT_CLOSE;
            acc_next  = {(VALUE_W - 8)'(0), stage_char};
          end
        end
        LM_LIT_ESC: begin
          mode_next = LM_LIT_CLOSE;
          if (stage_char == CH_LOW_N) begin
            acc_next = {(VALUE_W - 8)'(0), CH_LF};
          end else if (stage_char == CH_LOW_T) begin
            acc_next = {(VALUE_W - 8)'(0), CH_TAB};
          end else if (stage_char == CH_LOW_B) begin
            acc_next = VALUE_W'(8);
          end else begin
            // unknown escape: the byte is dropped and an error token is emitted
            post_valid    = 1'b1;
            post_tok.kind = TK_ERROR;
            mode_next     = LM_IDLE;
            acc_next      = '0;
          end
        end
        LM_LIT_CLOSE: begin
          post_valid = 1'b1;
          if (stage_char == CH_QUOTE) begin
            post_tok.kind  = TK_CHAR;
            post_tok.value = acc;
          end else begin
            post_tok.kind = TK_ERROR;
          end
          mode_next = LM_IDLE;
          acc_next  = '0;
        end
        default: begin
          post_valid     = id_emit;
          post_tok.kind  = id_kind;
          post_tok.value = id_value;
          mode_next      = id_mode;
          acc_next       = id_acc;
        end
      endcase
    end
  end

  // pack the tokens in order and mark the final one
  always_comb begin
    push.tok0 = pre_valid ? pre_tok : post_tok;
    push.tok1 = post_tok;
    push.tok0.last = !(pre_valid && post_valid);
    push.tok1.last = 1'b1;
    if (!stage_valid) begin
      push.count = 2'd0;
    end else begin
      push.count = {1'b0, pre_valid} + {1'b0, post_valid};
    end
  end

endmodule

`default_nettype wire

// ===== src/et_token_fifo.sv =====
// small token queue: up to two writes and one read per cycle
`default_nettype none

module et_token_fifo
  import et_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  lex_push_t          push,
  input  logic               pop,
  output token_t             head,
  output logic               head_valid,
  output logic [FIFO_AW:0]   level
);

  token_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   level_next;

  assign level_next = level + {{(FIFO_AW - 1){1'b0}}, push.count} -
                      {{FIFO_AW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count[FIFO_AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.tok1;
    end
  end

  assign head       = mem[rd_ptr];
  assign head_valid = (level != '0);

endmodule

`default_nettype wire

// ===== src/expression_tokenizer.sv =====
// expression tokenizer top level
//
// in_ch carries one source byte per item, or an end-of-text mark (the byte is
// then ignored). out_tok carries one token per item: kind, value and a flag on
// the last token that a given input item produced. An input item gives zero,
// one or two tokens.
// An accepted item is registered, decoded in the next cycle against the lexer
// state and its tokens are written into a four-entry queue. The first token is
// offered on out_tok once it has been written into the queue; a second token
// from the same item is offered once the first has been taken.
// in_ch.ready is high while the queue level plus the tokens of the item being
// decoded leaves room for two more, so one item per cycle is taken as long as
// the receiver takes about one token per cycle; the single output port sets
// the sustained rate when items give two tokens.
// When the receiver stalls the queue fills and in_ch.ready drops; nothing is
// lost. Synchronous reset empties the queue, drops the registered item and
// returns the lexer to idle with the number accumulator cleared.
`default_nettype none

module expression_tokenizer
  import et_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  et_char_if.sink           in_ch,
  et_token_if.source        out_tok
);

  lex_push_t        push;
  token_t           head;
  logic             head_valid;
  logic [FIFO_AW:0] level;
  logic             in_accept;
  logic             pop;
  logic             pair_last_ok;
  logic             eot_taken;
  logic             eof_pushed;

  assign in_ch.ready = ({1'b0, level} + {{FIFO_AW{1'b0}}, push.count}) <=
                       (FIFO_AW + 2)'(FIFO_DEPTH - 2);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign pop         = head_valid && out_tok.ready;

  et_lexer u_lexer (
    .clk         (clk),
    .rst         (rst),
    .load        (in_accept),
    .char_code   (in_ch.char_code),
    .end_of_text (in_ch.end_of_text),
    .push        (push)
  );

  et_token_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .level      (level)
  );

  assign out_tok.valid       = head_valid;
  assign out_tok.token_kind  = head.kind;
  assign out_tok.token_value = head.value;
  assign out_tok.last_of_run = head.last;

  assign pair_last_ok = push.tok1.last && !push.tok0.last;
  assign eot_taken    = in_accept && in_ch.end_of_text;
  assign eof_pushed   = (push.count == 2'd1 && push.tok0.kind == TK_EOF) ||
                        (push.count == 2'd2 && push.tok1.kind == TK_EOF);

`include "expression_tokenizer_assert.svh"

  `ET_ASSERT_ALWAYS(a_fifo_bound, level <= (FIFO_AW + 1)'(FIFO_DEPTH), "token queue overflow")
  `ET_ASSERT_SAME(a_pair_last, push.count == 2'd2, pair_last_ok, "bad last flag on token pair")
  `ET_ASSERT_NEXT(a_eot_eof, eot_taken, eof_pushed, "end of text without eof token")

endmodule

`default_nettype wire
